// ----- rtl/itpp_pkg.sv -----
// shared constants, types and character helpers for the expression converter
`timescale 1ns / 1ps

package itpp_pkg;

  localparam int MAX_LEN = 64;
  localparam int PTR_W   = $clog2(MAX_LEN);
  localparam int CNT_W   = $clog2(MAX_LEN + 1);

  typedef logic [7:0] char_t;

  localparam char_t CH_POW    = 8'h5E;
  localparam char_t CH_MUL    = 8'h2A;
  localparam char_t CH_DIV    = 8'h2F;
  localparam char_t CH_ADD    = 8'h2B;
  localparam char_t CH_SUB    = 8'h2D;
  localparam char_t CH_LPAREN = 8'h28;
  localparam char_t CH_RPAREN = 8'h29;
  localparam char_t CH_DIG_LO = 8'h30;
  localparam char_t CH_DIG_HI = 8'h39;
  localparam char_t CH_UPP_LO = 8'h41;
  localparam char_t CH_UPP_HI = 8'h5A;
  localparam char_t CH_LOW_LO = 8'h61;
  localparam char_t CH_LOW_HI = 8'h7A;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISP,
    S_FEED,
    S_POPW,
    S_AFTER,
    S_RDREQ,
    S_RDWAIT,
    S_FLUSH,
    S_END,
    S_EMRD,
    S_EMOUT
  } fsm_state_t;

  typedef struct packed {
    logic take;
    logic feed;
    logic conv_start;
    logic push;
    logic pop;
    logic load_top;
    logic emit_top;
    logic emit_cur;
    logic rd_in;
    logic load_cur;
    logic out_end;
    logic rd_ob;
    logic out_ob;
    logic clear;
  } ctrl_cmd_t;

  typedef struct packed {
    logic prefix;
    logic cur_last;
    logic acc;
    logic cls_alnum;
    logic cls_lparen;
    logic cls_rparen;
    logic cls_op;
    logic sp_zero;
    logic top_lparen;
    logic top_ge;
    logic pend_v;
    logic slot_free;
    logic emit_ok;
    logic idx_zero;
    logic ob_zero;
  } dp_stat_t;

  function automatic logic is_alnum(input char_t c);
    return (c >= CH_DIG_LO && c <= CH_DIG_HI) ||
           (c >= CH_UPP_LO && c <= CH_UPP_HI) ||
           (c >= CH_LOW_LO && c <= CH_LOW_HI);
  endfunction

  function automatic logic is_op(input char_t c);
    return c == CH_ADD || c == CH_SUB || c == CH_MUL || c == CH_DIV || c == CH_POW;
  endfunction

  function automatic logic is_kept(input char_t c);
    return is_alnum(c) || is_op(c) || c == CH_LPAREN || c == CH_RPAREN;
  endfunction

  // precedence; zero for an open bracket so it never gets popped by an operator
  function automatic logic [1:0] rank(input char_t c);
    logic [1:0] r;
    case (c)
      CH_POW:         r = 2'd3;
      CH_MUL, CH_DIV: r = 2'd2;
      CH_ADD, CH_SUB: r = 2'd1;
      default:        r = 2'd0;
    endcase
    return r;
  endfunction

  function automatic char_t swap_paren(input char_t c);
    char_t r;
    case (c)
      CH_LPAREN: r = CH_RPAREN;
      CH_RPAREN: r = CH_LPAREN;
      default:   r = c;
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/itpp_if.sv -----
// valid/ready channel interfaces for input, result and configuration
`timescale 1ns / 1ps

interface itpp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_char;
  logic       in_last;

  modport source (output valid, in_char, in_last, input ready);
  modport sink   (input valid, in_char, in_last, output ready);
endinterface

interface itpp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       out_empty;
  logic       out_last;
  logic       error;

  modport source (output valid, out_char, out_empty, out_last, error, input ready);
  modport sink   (input valid, out_char, out_empty, out_last, error, output ready);
endinterface

interface itpp_cfg_if;
  logic valid;
  logic ready;
  logic output_form;

  modport source (output valid, output_form, input ready);
  modport sink   (input valid, output_form, output ready);
endinterface

// ----- rtl/itpp_ctrl.sv -----
// sequencer for the shunting-yard conversion
`timescale 1ns / 1ps

module itpp_ctrl import itpp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  dp_stat_t  stat,
  output ctrl_cmd_t cmd
);

  fsm_state_t state_r, state_nxt;
  fsm_state_t ret_r, ret_nxt;

  logic feed_pop;
  logic feed_drop_lp;

  // pop an operator out during feed, or drop the matching open bracket
  assign feed_pop = (stat.cls_rparen && !stat.sp_zero && !stat.top_lparen) ||
                    (stat.cls_op && !stat.sp_zero && stat.top_ge);
  assign feed_drop_lp = stat.cls_rparen && !stat.sp_zero && stat.top_lparen;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ret_r   <= S_IDLE;
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ret_nxt   = ret_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_DISP;
      end
      S_DISP: begin
        if (stat.prefix) state_nxt = stat.cur_last ? S_RDREQ : S_IDLE;
        else if (stat.acc) state_nxt = S_FEED;
        else state_nxt = stat.cur_last ? S_FLUSH : S_END;
      end
      S_FEED: begin
        if (stat.cls_alnum) begin
          if (stat.emit_ok) state_nxt = S_AFTER;
        end else if (stat.cls_lparen) begin
          state_nxt = S_AFTER;
        end else if (feed_pop) begin
          if (stat.emit_ok) begin
            state_nxt = S_POPW;
            ret_nxt   = S_FEED;
          end
        end else if (feed_drop_lp) begin
          state_nxt = S_POPW;
          ret_nxt   = S_AFTER;
        end else begin
          state_nxt = S_AFTER;
        end
      end
      S_POPW: begin
        state_nxt = ret_r;
      end
      S_AFTER: begin
        if (stat.prefix) state_nxt = S_RDREQ;
        else state_nxt = stat.cur_last ? S_FLUSH : S_END;
      end
      S_RDREQ: begin
        state_nxt = stat.idx_zero ? S_FLUSH : S_RDWAIT;
      end
      S_RDWAIT: begin
        state_nxt = S_FEED;
      end
      S_FLUSH: begin
        if (!stat.sp_zero) begin
          if (stat.emit_ok) begin
            state_nxt = S_POPW;
            ret_nxt   = S_FLUSH;
          end
        end else begin
          state_nxt = stat.prefix ? S_EMRD : S_END;
        end
      end
      S_END: begin
        if (stat.cur_last || stat.pend_v) begin
          if (stat.slot_free) state_nxt = S_IDLE;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_EMRD: begin
        state_nxt = stat.ob_zero ? S_END : S_EMOUT;
      end
      S_EMOUT: begin
        if (stat.slot_free) state_nxt = stat.ob_zero ? S_IDLE : S_EMRD;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.take = in_valid;
      end
      S_DISP: begin
        cmd.conv_start = stat.prefix && stat.cur_last;
      end
      S_FEED: begin
        cmd.feed     = 1'b1;
        cmd.emit_cur = stat.cls_alnum && stat.emit_ok;
        cmd.push     = stat.cls_lparen || (stat.cls_op && !feed_pop);
        cmd.emit_top = feed_pop && stat.emit_ok;
        cmd.pop      = (feed_pop && stat.emit_ok) || feed_drop_lp;
      end
      S_POPW: begin
        cmd.load_top = 1'b1;
      end
      S_RDREQ: begin
        cmd.rd_in = !stat.idx_zero;
      end
      S_RDWAIT: begin
        cmd.load_cur = 1'b1;
      end
      S_FLUSH: begin
        cmd.emit_top = !stat.sp_zero && stat.emit_ok;
        cmd.pop      = !stat.sp_zero && stat.emit_ok;
      end
      S_END: begin
        cmd.out_end = (stat.cur_last || stat.pend_v) && stat.slot_free;
        cmd.clear   = stat.cur_last && stat.slot_free;
      end
      S_EMRD: begin
        cmd.rd_ob = !stat.ob_zero;
      end
      S_EMOUT: begin
        cmd.out_ob = stat.slot_free;
        cmd.clear  = stat.slot_free && stat.ob_zero;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// ----- rtl/itpp_dp.sv -----
// datapath: operator stack, input and output buffers, counters and result register
`timescale 1ns / 1ps

module itpp_dp import itpp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  char_t     in_char,
  input  logic      in_last,
  input  logic      cfg_we,
  input  logic      cfg_form,
  input  ctrl_cmd_t cmd,
  output dp_stat_t  stat,
  input  logic      out_ready,
  output logic      out_valid,
  output char_t     out_char,
  output logic      out_empty,
  output logic      out_last,
  output logic      out_error
);

  char_t stk_mem [MAX_LEN];
  char_t inb_mem [MAX_LEN];
  char_t ob_mem  [MAX_LEN];

  char_t stk_rd_r, inb_rd_r, ob_rd_r;

  logic             form_r, form_nxt;
  char_t            cur_r, cur_nxt;
  logic             last_r, last_nxt;
  logic             acc_r, acc_nxt;
  logic [CNT_W-1:0] sp_r, sp_nxt;
  char_t            top_r, top_nxt;
  logic [CNT_W-1:0] open_r, open_nxt;
  logic [CNT_W-1:0] in_cnt_r, in_cnt_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic [CNT_W-1:0] ob_cnt_r, ob_cnt_nxt;
  logic             err_r, err_nxt;
  char_t            pend_r, pend_nxt;
  logic             pend_v_r, pend_v_nxt;
  logic             out_valid_r, out_valid_nxt;
  char_t            out_char_r, out_char_nxt;
  logic             out_empty_r, out_empty_nxt;
  logic             out_last_r, out_last_nxt;
  logic             out_err_r, out_err_nxt;

  logic             kept, room;
  logic             emit;
  char_t            echar;
  logic             slot_free;
  logic             stk_we, inb_we, ob_we;
  logic [CNT_W-1:0] stk_rsum, inb_rsum, ob_rsum;

  assign kept      = is_kept(in_char);
  assign room      = in_cnt_r < CNT_W'(MAX_LEN);
  assign emit      = cmd.emit_top || cmd.emit_cur;
  assign echar     = cmd.emit_top ? top_r : cur_r;
  assign slot_free = !out_valid_r || out_ready;

  assign stk_rsum  = sp_r - CNT_W'(2);
  assign inb_rsum  = idx_r - CNT_W'(1);
  assign ob_rsum   = ob_cnt_r - CNT_W'(1);

  assign stk_we = cmd.push && (sp_r < CNT_W'(MAX_LEN));
  assign inb_we = cmd.take && kept && room && form_r;
  assign ob_we  = emit && form_r && (ob_cnt_r < CNT_W'(MAX_LEN));

  always_comb begin
    form_nxt      = form_r;
    cur_nxt       = cur_r;
    last_nxt      = last_r;
    acc_nxt       = acc_r;
    sp_nxt        = sp_r;
    top_nxt       = top_r;
    open_nxt      = open_r;
    in_cnt_nxt    = in_cnt_r;
    idx_nxt       = idx_r;
    ob_cnt_nxt    = ob_cnt_r;
    err_nxt       = err_r;
    pend_nxt      = pend_r;
    pend_v_nxt    = pend_v_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_char_nxt  = out_char_r;
    out_empty_nxt = out_empty_r;
    out_last_nxt  = out_last_r;
    out_err_nxt   = out_err_r;

    if (cmd.take) begin
      cur_nxt  = in_char;
      last_nxt = in_last;
      acc_nxt  = kept && room;
      if (kept && room) in_cnt_nxt = in_cnt_r + CNT_W'(1);
      if (kept && !room) err_nxt = 1'b1;
    end

    // close bracket with no open bracket on the stack
    if (cmd.feed && cur_r == CH_RPAREN && open_r == '0) err_nxt = 1'b1;

    if (cmd.conv_start) begin
      sp_nxt     = '0;
      open_nxt   = '0;
      ob_cnt_nxt = '0;
      idx_nxt    = in_cnt_r;
    end

    if (cmd.push) begin
      if (stk_we) begin
        sp_nxt  = sp_r + CNT_W'(1);
        top_nxt = cur_r;
        if (cur_r == CH_LPAREN) open_nxt = open_r + CNT_W'(1);
      end else begin
        err_nxt = 1'b1;
      end
    end

    if (cmd.pop) begin
      sp_nxt = sp_r - CNT_W'(1);
      if (top_r == CH_LPAREN && open_r != '0) open_nxt = open_r - CNT_W'(1);
    end

    if (cmd.load_top) top_nxt = stk_rd_r;

    if (emit) begin
      if (form_r) begin
        if (ob_we) ob_cnt_nxt = ob_cnt_r + CNT_W'(1);
      end else begin
        if (pend_v_r) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = pend_r;
          out_empty_nxt = 1'b0;
          out_last_nxt  = 1'b0;
          out_err_nxt   = err_r;
        end
        pend_nxt   = echar;
        pend_v_nxt = 1'b1;
      end
    end

    if (cmd.rd_in) idx_nxt = idx_r - CNT_W'(1);
    if (cmd.load_cur) cur_nxt = swap_paren(inb_rd_r);

    if (cmd.out_end) begin
      out_valid_nxt = 1'b1;
      out_char_nxt  = pend_v_r ? pend_r : '0;
      out_empty_nxt = !pend_v_r;
      out_last_nxt  = last_r;
      out_err_nxt   = err_r;
      pend_v_nxt    = 1'b0;
    end

    if (cmd.rd_ob) ob_cnt_nxt = ob_cnt_r - CNT_W'(1);

    if (cmd.out_ob) begin
      out_valid_nxt = 1'b1;
      out_char_nxt  = ob_rd_r;
      out_empty_nxt = 1'b0;
      out_last_nxt  = (ob_cnt_r == '0);
      out_err_nxt   = err_r;
    end

    if (cmd.clear) begin
      in_cnt_nxt = '0;
      sp_nxt     = '0;
      open_nxt   = '0;
      ob_cnt_nxt = '0;
      err_nxt    = 1'b0;
    end

    // mode change drops the expression in progress
    if (cfg_we) begin
      form_nxt   = cfg_form;
      in_cnt_nxt = '0;
      sp_nxt     = '0;
      open_nxt   = '0;
      ob_cnt_nxt = '0;
      err_nxt    = 1'b0;
      pend_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      form_r      <= 1'b0;
      last_r      <= 1'b0;
      acc_r       <= 1'b0;
      sp_r        <= '0;
      open_r      <= '0;
      in_cnt_r    <= '0;
      ob_cnt_r    <= '0;
      err_r       <= 1'b0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      form_r      <= form_nxt;
      last_r      <= last_nxt;
      acc_r       <= acc_nxt;
      sp_r        <= sp_nxt;
      open_r      <= open_nxt;
      in_cnt_r    <= in_cnt_nxt;
      ob_cnt_r    <= ob_cnt_nxt;
      err_r       <= err_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r       <= cur_nxt;
    top_r       <= top_nxt;
    idx_r       <= idx_nxt;
    pend_r      <= pend_nxt;
    out_char_r  <= out_char_nxt;
    out_empty_r <= out_empty_nxt;
    out_last_r  <= out_last_nxt;
    out_err_r   <= out_err_nxt;
  end

  // operator stack: new top is fetched one below the current top on a pop
  always_ff @(posedge clk) begin
    if (stk_we) stk_mem[sp_r[PTR_W-1:0]] <= cur_r;
    if (cmd.pop) stk_rd_r <= stk_mem[stk_rsum[PTR_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (inb_we) inb_mem[in_cnt_r[PTR_W-1:0]] <= in_char;
    if (cmd.rd_in) inb_rd_r <= inb_mem[inb_rsum[PTR_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (ob_we) ob_mem[ob_cnt_r[PTR_W-1:0]] <= echar;
    if (cmd.rd_ob) ob_rd_r <= ob_mem[ob_rsum[PTR_W-1:0]];
  end

  always_comb begin
    stat            = '0;
    stat.prefix     = form_r;
    stat.cur_last   = last_r;
    stat.acc        = acc_r;
    stat.cls_alnum  = is_alnum(cur_r);
    stat.cls_lparen = (cur_r == CH_LPAREN);
    stat.cls_rparen = (cur_r == CH_RPAREN);
    stat.cls_op     = is_op(cur_r);
    stat.sp_zero    = (sp_r == '0);
    stat.top_lparen = (top_r == CH_LPAREN);
    stat.top_ge     = rank(top_r) >= rank(cur_r);
    stat.pend_v     = pend_v_r;
    stat.slot_free  = slot_free;
    stat.emit_ok    = form_r || !pend_v_r || slot_free;
    stat.idx_zero   = (idx_r == '0);
    stat.ob_zero    = (ob_cnt_r == '0);
  end

  assign out_valid = out_valid_r;
  assign out_char  = out_char_r;
  assign out_empty = out_empty_r;
  assign out_last  = out_last_r;
  assign out_error = out_err_r;

endmodule

// ----- rtl/infix_to_postfix_prefix_core.sv -----
// top level of the infix to postfix / prefix expression converter
`timescale 1ns / 1ps

// channel   dir  payload                                  transaction when
// in_ch     in   in_char[7:0], in_last                     valid && ready
// out_ch    out  out_char[7:0], out_empty, out_last, error valid && ready
// cfg_ch    in   output_form                              valid && ready, always ready
//
// one character at a time, none taken until the last is done; postfix: a letter, digit, operator
// or bracket is fed through the stack, a popped entry waits on the stack read, a dropped byte
// skips the feed, and the final character also flushes the stack; prefix: characters are buffered,
// the final one converts them read backwards, then the results go out; a pop waits on the stack read
// rst_n is synchronous; it clears counts, the error flag and the form register
// a stalled result holds the sequencer in place; nothing is dropped

module infix_to_postfix_prefix_core import itpp_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  itpp_in_if.sink           in_ch,
  itpp_out_if.source        out_ch,
  itpp_cfg_if.sink          cfg_ch
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  // register writes are only expected between expressions
  assign cfg_ch.ready = 1'b1;

  itpp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  itpp_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_char   (in_ch.in_char),
    .in_last   (in_ch.in_last),
    .cfg_we    (cfg_ch.valid),
    .cfg_form  (cfg_ch.output_form),
    .cmd       (cmd),
    .stat      (stat),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .out_char  (out_ch.out_char),
    .out_empty (out_ch.out_empty),
    .out_last  (out_ch.out_last),
    .out_error (out_ch.error)
  );

endmodule

// ----- test/infix_to_postfix_prefix_core_test.sv -----
`timescale 1ns / 1ps
// testbench for the expression converter: directed and random expressions against a local model

module infix_to_postfix_prefix_core_test import itpp_pkg::*; ();

  localparam int   RANDOM_ITEMS  = 445;
  localparam int   PHASE_ITEMS   = 70;
  localparam int   CYCLE_LIMIT   = 600000;
  localparam int   SETTLE_CYCLES = 40;
  localparam int   DRAIN_CYCLES  = 100;
  localparam int   HOLD_CYCLES   = 300;
  localparam int   HOLD_SPACING  = 220;
  localparam int   MAX_REPORTS   = 10;
  localparam logic FORM_POSTFIX  = 1'b0;
  localparam logic FORM_PREFIX   = 1'b1;

  // one result transaction as seen on the output channel
  typedef struct packed {
    char_t ch;
    logic  empty;
    logic  last;
    logic  err;
  } result_t;

  // one row of the directed table: a character or a form register write
  typedef struct packed {
    logic    is_cfg;
    logic    form;
    char_t   ch;
    logic    last;
    logic    typed;
    result_t want;
  } stim_row_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  itpp_in_if  in_bus();
  itpp_out_if res_bus();
  itpp_cfg_if cfg_bus();

  infix_to_postfix_prefix_core DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (res_bus),
    .cfg_ch (cfg_bus)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // shunting-yard model: own copy of the form register and expression state
  // ---------------------------------------------------------------------------
  logic    model_form;
  char_t   op_stack [MAX_LEN];
  int      op_depth;
  char_t   char_buf [MAX_LEN];
  int      char_cnt;
  logic    err_flag;
  char_t   conv_q[$];           // characters emitted by the current conversion
  result_t step_res[$];         // results caused by the latest character
  result_t pending_results[$];  // results still owed by the block, oldest first

  function automatic result_t mk_result(char_t c, logic empty, logic last, logic err);
    result_t r;
    r.ch    = c;
    r.empty = empty;
    r.last  = last;
    r.err   = err;
    return r;
  endfunction

  function automatic logic is_operand(char_t c);
    return (c >= CH_DIG_LO && c <= CH_DIG_HI) || (c >= CH_UPP_LO && c <= CH_UPP_HI) ||
           (c >= CH_LOW_LO && c <= CH_LOW_HI);
  endfunction

  function automatic logic is_operator_char(char_t c);
    return c == CH_ADD || c == CH_SUB || c == CH_MUL || c == CH_DIV || c == CH_POW;
  endfunction

  function automatic logic keeps_char(char_t c);
    return is_operand(c) || is_operator_char(c) || c == CH_LPAREN || c == CH_RPAREN;
  endfunction

  // an open bracket ranks below every operator so it is never popped by one
  function automatic int precedence_of(char_t c);
    case (c)
      CH_POW:         return 3;
      CH_MUL, CH_DIV: return 2;
      CH_ADD, CH_SUB: return 1;
      default:        return 0;
    endcase
  endfunction

  function void emit_char(char_t c);
    if (conv_q.size() < MAX_LEN) conv_q.push_back(c);
  endfunction

  function void stack_push(char_t c);
    if (op_depth < MAX_LEN) begin
      op_stack[op_depth] = c;
      op_depth++;
    end else begin
      err_flag = 1'b1;
    end
  endfunction

  function void feed_char(char_t c);
    if (is_operand(c)) begin
      emit_char(c);
    end else if (c == CH_LPAREN) begin
      stack_push(c);
    end else if (c == CH_RPAREN) begin
      while (op_depth > 0 && op_stack[op_depth-1] != CH_LPAREN) begin
        emit_char(op_stack[op_depth-1]);
        op_depth--;
      end
      // unmatched close bracket: stack is empty, flag it
      if (op_depth > 0) op_depth--;
      else err_flag = 1'b1;
    end else if (is_operator_char(c)) begin
      while (op_depth > 0 && precedence_of(op_stack[op_depth-1]) >= precedence_of(c)) begin
        emit_char(op_stack[op_depth-1]);
        op_depth--;
      end
      stack_push(c);
    end
  endfunction

  // end of expression: anything left, an unmatched open bracket included, goes out
  function void drain_stack();
    while (op_depth > 0) begin
      emit_char(op_stack[op_depth-1]);
      op_depth--;
    end
  endfunction

  function void clear_expression();
    op_depth = 0;
    char_cnt = 0;
    err_flag = 1'b0;
  endfunction

  function void apply_form(logic v);
    model_form = v;
    clear_expression();
  endfunction

  // works out the results of one accepted character into step_res
  function void convert_step(char_t c, logic last);
    logic  taken;
    int    n;
    int    i;
    char_t r;
    conv_q.delete();
    step_res.delete();
    taken = 1'b0;
    // length limit applies to kept characters in both forms
    if (keeps_char(c)) begin
      if (char_cnt < MAX_LEN) begin
        taken = 1'b1;
        if (model_form == FORM_PREFIX) char_buf[char_cnt] = c;
        char_cnt++;
      end else begin
        err_flag = 1'b1;
      end
    end
    if (model_form == FORM_PREFIX) begin
      if (!last) return;
      // convert the reversed text with brackets swapped, then emit backwards
      op_depth = 0;
      for (i = char_cnt; i > 0; i--) begin
        r = char_buf[i-1];
        if (r == CH_LPAREN) r = CH_RPAREN;
        else if (r == CH_RPAREN) r = CH_LPAREN;
        feed_char(r);
      end
      drain_stack();
      n = conv_q.size();
      for (i = 0; i < n; i++)
        step_res.push_back(mk_result(conv_q[n-1-i], 1'b0, i == n - 1, err_flag));
    end else begin
      if (taken) feed_char(c);
      if (last) drain_stack();
      n = conv_q.size();
      for (i = 0; i < n; i++)
        step_res.push_back(mk_result(conv_q[i], 1'b0, last && i == n - 1, err_flag));
    end
    if (last) begin
      // nothing emitted on the final character: a lone status result
      if (step_res.size() == 0) step_res.push_back(mk_result(8'h00, 1'b1, 1'b1, err_flag));
      clear_expression();
    end
  endfunction

  // ---------------------------------------------------------------------------
  // directed table
  // ---------------------------------------------------------------------------
  stim_row_t dir_rows[$];

  function void add_row(char_t c, logic last, logic typed, result_t want);
    stim_row_t row;
    row.is_cfg = 1'b0;
    row.form   = FORM_POSTFIX;
    row.ch     = c;
    row.last   = last;
    row.typed  = typed;
    row.want   = want;
    dir_rows.push_back(row);
  endfunction

  function void add_text(string s, logic end_last);
    int i;
    for (i = 0; i < s.len(); i++)
      add_row(s[i], end_last && i == s.len() - 1, 1'b0, '0);
  endfunction

  function void add_form(logic v);
    stim_row_t row;
    row       = '0;
    row.is_cfg = 1'b1;
    row.form   = v;
    dir_rows.push_back(row);
  endfunction

  // ---------------------------------------------------------------------------
  // random expression source
  // ---------------------------------------------------------------------------
  char_t expr_q[$];

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic char_t rand_operand();
    int idx;
    idx = $urandom_range(0, 61);
    if (idx < 10) return char_t'(CH_DIG_LO + idx);
    if (idx < 36) return char_t'(CH_UPP_LO + (idx - 10));
    return char_t'(CH_LOW_LO + (idx - 36));
  endfunction

  function automatic char_t rand_operator();
    case ($urandom_range(0, 4))
      0:       return CH_ADD;
      1:       return CH_SUB;
      2:       return CH_MUL;
      3:       return CH_DIV;
      default: return CH_POW;
    endcase
  endfunction

  // well-formed operand/operator chains with a little noise and some broken brackets
  function void build_expression(int n_tok);
    int depth;
    int t;
    expr_q.delete();
    depth = 0;
    for (t = 0; t < n_tok; t++) begin
      if (t > 0) expr_q.push_back(rand_operator());
      while ($urandom_range(0, 3) == 0 && depth < 8) begin
        expr_q.push_back(CH_LPAREN);
        depth++;
      end
      expr_q.push_back(rand_operand());
      while (depth > 0 && $urandom_range(0, 2) == 0) begin
        expr_q.push_back(CH_RPAREN);
        depth--;
      end
      if ($urandom_range(0, 19) == 0) expr_q.push_back(char_t'($urandom_range(0, 255)));
    end
    if ($urandom_range(0, 4) != 0) begin
      while (depth > 0) begin
        expr_q.push_back(CH_RPAREN);
        depth--;
      end
    end
    // stray close bracket somewhere in the text
    if ($urandom_range(0, 9) == 0)
      expr_q.insert($urandom_range(0, expr_q.size()), CH_RPAREN);
  endfunction

  // ---------------------------------------------------------------------------
  // input side: drive at the falling edge, transaction seen at the rising edge
  // ---------------------------------------------------------------------------
  task automatic deliver(char_t c, logic last, int gap, logic typed, result_t want);
    repeat (gap) begin
      @(negedge clk);
      in_bus.valid <= 1'b0;
    end
    @(negedge clk);
    in_bus.valid   <= 1'b1;
    in_bus.in_char <= c;
    in_bus.in_last <= last;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    convert_step(c, last);
    // a typed row replaces the model's answer with the one written in the table
    if (typed) pending_results.push_back(want);
    else foreach (step_res[i]) pending_results.push_back(step_res[i]);
  endtask

  // sender stops offering until the block has handed over everything owed
  task automatic wait_idle();
    @(negedge clk);
    in_bus.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_form(logic v);
    wait_idle();
    // a push with no result may still be in flight, let it settle
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_bus.valid       <= 1'b1;
    cfg_bus.output_form <= v;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    apply_form(v);
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // result side: ready pattern, long hold-offs and checking
  // ---------------------------------------------------------------------------
  int results_seen = 0;
  int mismatch_cnt = 0;
  int hold_left    = 0;
  int stall_left   = 0;
  int burst_left   = 0;
  int holds_done   = 0;
  int next_hold_at = 80;
  int cycle_cnt    = 0;

  always @(negedge clk) begin
    // long hold-off so the block backs up and stalls its input
    if (hold_left == 0 && holds_done < 2 && results_seen >= next_hold_at) begin
      hold_left    = HOLD_CYCLES;
      holds_done++;
      next_hold_at = next_hold_at + HOLD_SPACING;
    end
    if (hold_left > 0) begin
      res_bus.ready <= 1'b0;
      hold_left--;
    end else if (burst_left > 0) begin
      res_bus.ready <= 1'b1;
      burst_left--;
    end else if (stall_left > 0) begin
      res_bus.ready <= 1'b0;
      stall_left--;
    end else begin
      res_bus.ready <= 1'b1;
      case ($urandom_range(0, 19))
        0:             burst_left = $urandom_range(30, 80);
        1, 2, 3, 4, 5: stall_left = pick_gap();
        default:       ;
      endcase
    end
  end

  always @(posedge clk) begin : check_results
    result_t got;
    result_t want;
    if (rst_n && res_bus.valid && res_bus.ready) begin
      results_seen++;
      got = mk_result(res_bus.out_char, res_bus.out_empty, res_bus.out_last, res_bus.error);
      if (pending_results.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= MAX_REPORTS)
          $display("unexpected result: char %h empty %b last %b error %b",
                   got.ch, got.empty, got.last, got.err);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          mismatch_cnt++;
          if (mismatch_cnt <= MAX_REPORTS)
            $display({"result %0d: expected char %h empty %b last %b error %b, ",
                      "got char %h empty %b last %b error %b"},
                     results_seen, want.ch, want.empty, want.last, want.err,
                     got.ch, got.empty, got.last, got.err);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("infix_to_postfix_prefix_core_test: FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin : main_seq
    int       kept_sent;
    int       phase_items;
    int       phase;
    logic     form;
    logic     burst;
    int       n_tok;
    int       k;
    char_t    c;

    in_bus.valid        = 1'b0;
    in_bus.in_char      = 8'h00;
    in_bus.in_last      = 1'b0;
    cfg_bus.valid       = 1'b0;
    cfg_bus.output_form = FORM_POSTFIX;
    apply_form(FORM_POSTFIX);

    // results fixed by inspection: single operand, unmatched close bracket, dropped bytes
    add_row("a", 1'b1, 1'b1, mk_result("a", 1'b0, 1'b1, 1'b0));
    add_row(CH_RPAREN, 1'b1, 1'b1, mk_result(8'h00, 1'b1, 1'b1, 1'b1));
    add_row(8'hFF, 1'b1, 1'b1, mk_result(8'h00, 1'b1, 1'b1, 1'b0));
    add_row(8'h00, 1'b1, 1'b1, mk_result(8'h00, 1'b1, 1'b1, 1'b0));
    // power is left-associative, brackets group
    add_text("a^b^(C-9)", 1'b1);
    // multiply, divide, add, and an open bracket left on the stack at the end
    add_text("A*0/z+(", 1'b1);
    // expression abandoned halfway by a register write
    add_text("q-", 1'b0);
    add_form(FORM_PREFIX);
    add_text("a-b*c", 1'b1);

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) write_form(dir_rows[i].form);
      else deliver(dir_rows[i].ch, dir_rows[i].last, pick_gap(), dir_rows[i].typed,
                   dir_rows[i].want);
    end

    // random phases, alternating form with the odd repeat
    kept_sent = 0;
    phase     = 0;
    while (kept_sent < RANDOM_ITEMS) begin
      form = phase[0] ^ ($urandom_range(0, 3) == 0);
      write_form(form);
      phase_items = 0;
      while (phase_items < PHASE_ITEMS && kept_sent < RANDOM_ITEMS) begin
        if ($urandom_range(0, 19) == 0) begin
          // lone byte of any value as a whole expression
          expr_q.delete();
          expr_q.push_back(char_t'($urandom_range(0, 255)));
        end else begin
          // mostly short, a few long enough to hit the length limit
          n_tok = ($urandom_range(0, 14) == 0) ? $urandom_range(25, 40) : $urandom_range(1, 6);
          build_expression(n_tok);
        end
        burst = ($urandom_range(0, 4) == 0);
        for (k = 0; k < expr_q.size(); k++) begin
          c = expr_q[k];
          deliver(c, k == expr_q.size() - 1, burst ? 0 : pick_gap(), 1'b0, '0);
          if (keeps_char(c)) begin
            kept_sent++;
            phase_items++;
          end
        end
        // now and then hold back until the block has drained
        if ($urandom_range(0, 9) == 0) wait_idle();
      end
      phase++;
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0 && pending_results.size() == 0) begin
      $display("infix_to_postfix_prefix_core_test: PASS");
    end else begin
      $display("infix_to_postfix_prefix_core_test: FAIL");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/itpp_pkg.sv
rtl/itpp_if.sv
rtl/itpp_ctrl.sv
rtl/itpp_dp.sv
rtl/infix_to_postfix_prefix_core.sv
test/infix_to_postfix_prefix_core_test.sv
